@@ design/dqe_pkg.sv @@
// Shared types and codes for the double-ended queue with erase.
// Used by the core and its testbench; dqe_ram does not need it. It depends on nothing.
package dqe_pkg;

    localparam int VALUE_W = 64;
    localparam int POS_W   = 4;
    localparam int CNT_W   = 5;

    typedef enum logic [1:0] {
        FUNC_PUSH_BACK = 2'd0,
        FUNC_POP_FRONT = 2'd1,
        FUNC_POP_BACK  = 2'd2,
        FUNC_ERASE     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2,
        ERR_RANGE = 2'd3
    } t_err;

    typedef struct packed {
        t_func                     func;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
        logic                      use_last;
    } t_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0] front_value;
        logic [CNT_W-1:0]          count;
        logic                      empty_res;
        t_err                      error;
    } t_res;

endpackage

@@ design/dqe_ram.sv @@
// Slot store of the queue: one write port and one read port with registered read data.
// Stand-alone; no package needed.
module dqe_ram #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/double_ended_queue_with_erase_core.sv @@
// Top level of the bounded double-ended queue with erase.
// Depends on dqe_pkg for its types and codes and instantiates dqe_ram.
//
// A request word is taken at a rising edge where i_start is high and o_busy is low. Exactly
// one result word follows, shown on o_res for a single cycle with o_valid high; the receiver
// cannot hold it off, so it must capture the word in that cycle. Push, pop back, erase of the
// last element and any refused request pass through S_FRONT and S_FWAIT, during which o_busy
// stays high, and the result word is registered on leaving S_FWAIT. Pop front and erase of a
// middle element first move every later element one slot forward through the single slot
// memory, an S_RD read and an S_WR write per element, before going on to S_FRONT (pop front
// is erase at position 0). The front value is always read back from slot 0 of the memory at
// the end of the request. After reset the queue is empty and no clearing pass is needed.
module double_ended_queue_with_erase_core #(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  dqe_pkg::t_req i_req,
    output logic          o_busy,
    output logic          o_valid,
    output dqe_pkg::t_res o_res
);

    // Address width of the slots, width of the element count, and widths wide enough for
    // the comparisons against the request position and for the count field.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam int SW = FW + 1;
    localparam int CW = (FW > dqe_pkg::POS_W) ? FW : dqe_pkg::POS_W;
    localparam int XW = (FW > dqe_pkg::CNT_W) ? FW : dqe_pkg::CNT_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RD    = 5'b00010,
        S_WR    = 5'b00100,
        S_FRONT = 5'b01000,
        S_FWAIT = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    logic [FW-1:0] r_fill,  n_fill;
    logic [AW-1:0] r_idx,   n_idx;
    dqe_pkg::t_err r_err,   n_err;
    logic          r_valid, n_valid;
    dqe_pkg::t_res r_res,   n_res;

    // Slot memory control.
    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic signed [dqe_pkg::VALUE_W-1:0] ram_wdata;
    logic                            ram_re;
    logic [AW-1:0]                   ram_raddr;
    logic signed [dqe_pkg::VALUE_W-1:0] ram_rdata;

    // The shared step unit: widened index and fill, used both to launch a shift and to
    // decide whether another element must move forward.
    logic [SW-1:0] idx_step;
    logic [SW-1:0] fill_s;
    logic [CW-1:0] pos_c;
    logic [CW-1:0] fill_c;
    logic [AW-1:0] start_idx;
    logic [XW-1:0] fill_x;

    dqe_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (dqe_pkg::VALUE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign pos_c  = CW'(i_req.position);
    assign fill_c = CW'(r_fill);
    assign fill_s = SW'(r_fill);
    assign fill_x = XW'(n_fill);

    // The first slot to be overwritten: the front for pop front, otherwise the erase target.
    // The target is known to lie below the fill when it is used, so it fits the address.
    always_comb begin
        if (i_req.func == dqe_pkg::FUNC_POP_FRONT) begin
            start_idx = '0;
        end else begin
            start_idx = pos_c[AW-1:0];
        end
    end

    // In idle the unit tests whether a slot beyond the start exists; while shifting it tests
    // whether the slot after the next one still holds an element.
    always_comb begin
        if (r_state == S_IDLE) begin
            idx_step = SW'(start_idx) + SW'(1);
        end else begin
            idx_step = SW'(r_idx) + SW'(2);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_idx     = r_idx;
        n_err     = r_err;
        n_valid   = 1'b0;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = r_idx + AW'(1);

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_err   = dqe_pkg::ERR_OK;
                    n_state = S_FRONT;
                    if (i_req.func == dqe_pkg::FUNC_PUSH_BACK) begin
                        if (r_fill == FW'(DEPTH)) begin
                            n_err = dqe_pkg::ERR_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(r_fill);
                            ram_wdata = i_req.value;
                            n_fill    = r_fill + FW'(1);
                        end
                    end else if (r_fill == '0) begin
                        // An empty queue is reported ahead of any range problem.
                        n_err = dqe_pkg::ERR_EMPTY;
                    end else if (i_req.func == dqe_pkg::FUNC_POP_BACK ||
                                 (i_req.func == dqe_pkg::FUNC_ERASE && i_req.use_last)) begin
                        n_fill = r_fill - FW'(1);
                    end else if (i_req.func == dqe_pkg::FUNC_ERASE && pos_c >= fill_c) begin
                        n_err = dqe_pkg::ERR_RANGE;
                    end else begin
                        n_idx = start_idx;
                        if (idx_step < fill_s) begin
                            n_state = S_RD;
                        end else begin
                            // The target is the last element: nothing has to move.
                            n_fill = r_fill - FW'(1);
                        end
                    end
                end
            end
            S_RD: begin
                ram_re  = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                ram_we = 1'b1;
                n_idx  = r_idx + AW'(1);
                if (idx_step < fill_s) begin
                    n_state = S_RD;
                end else begin
                    n_fill  = r_fill - FW'(1);
                    n_state = S_FRONT;
                end
            end
            S_FRONT: begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                n_state   = S_FWAIT;
            end
            S_FWAIT: begin
                n_valid           = 1'b1;
                n_res.front_value = (r_fill != '0) ? ram_rdata : '0;
                n_res.count       = fill_x[dqe_pkg::CNT_W-1:0];
                n_res.empty_res   = (r_fill == '0);
                n_res.error       = r_err;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_err <= n_err;
        r_res <= n_res;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

@@ tb/double_ended_queue_with_erase_core_tb.sv @@
// Self-checking testbench for double_ended_queue_with_erase_core.
// Depends on dqe_pkg and the core; a table of directed words is followed by random traffic,
// and every result word is checked against a typed result or a behavioural deque in this file.
module double_ended_queue_with_erase_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dqe_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_WORDS = 950;
    // Slowest request is erase of the front of a full queue.
    localparam int WORST_LATENCY = 3 + 2 * (DEPTH - 1);
    localparam int TAIL_CYCLES   = WORST_LATENCY + 8;
    // Every word waiting out the longest gap and the worst latency, taken several times over.
    localparam int LIMIT_CYCLES  = 8 * (RANDOM_WORDS + 40) * (10 + WORST_LATENCY);
    localparam int PRINT_CAP     = 100;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 64'sh8000_0000_0000_0000;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_start;
    t_req  i_req;
    logic  o_busy;
    logic  o_valid;
    t_res  o_res;

    double_ended_queue_with_erase_core #(
        .DEPTH (DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    // One row of the directed table. Where typed is set, the result word is the one written
    // in the row; otherwise the behavioural deque supplies it.
    typedef struct {
        t_req req;
        bit   typed;
        t_res res;
    } t_row;

    // Behavioural copy of the deque: slot 0 is the front.
    logic signed [VALUE_W-1:0] dq_slots [DEPTH];
    int                        dq_fill;

    t_res  expected_results [$];
    t_row  directed_rows [$];
    int    words_taken;
    int    mismatches;
    int    cycles;
    bit    word_typed;
    t_res  word_typed_res;
    bit    filling;
    bit    no_idle;

    // Free-running clock, 10 ns period.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP) begin
            $display("MISMATCH at cycle %0d: %s", cycles, msg);
        end
        mismatches++;
    endtask

    // Applies one request word to the behavioural deque and returns the result word that the
    // block ought to produce for it. Refused requests leave the deque untouched.
    function automatic t_res deque_apply(input t_req r);
        t_res res;
        t_err err;
        int   idx;
        err = ERR_OK;
        idx = -1;
        case (r.func)
            FUNC_PUSH_BACK: begin
                if (dq_fill >= DEPTH) begin
                    err = ERR_FULL;
                end else begin
                    dq_slots[dq_fill] = r.value;
                    dq_fill++;
                end
            end
            FUNC_POP_FRONT: begin
                if (dq_fill == 0) err = ERR_EMPTY;
                else idx = 0;
            end
            FUNC_POP_BACK: begin
                if (dq_fill == 0) err = ERR_EMPTY;
                else idx = dq_fill - 1;
            end
            default: begin
                // An empty queue is reported before any range problem.
                if (dq_fill == 0) err = ERR_EMPTY;
                else if (r.use_last) idx = dq_fill - 1;
                else if (int'(r.position) >= dq_fill) err = ERR_RANGE;
                else idx = int'(r.position);
            end
        endcase
        if (idx >= 0) begin
            // Close the gap left by the removed element, keeping the order of the rest.
            for (int i = idx; i < dq_fill - 1; i++) begin
                dq_slots[i] = dq_slots[i + 1];
            end
            dq_fill--;
        end
        res.front_value = (dq_fill > 0) ? dq_slots[0] : '0;
        res.count       = CNT_W'(dq_fill);
        res.empty_res   = (dq_fill == 0);
        res.error       = err;
        return res;
    endfunction

    // Everything is sampled at the rising edge, where the inputs have been stable since the
    // previous falling edge. The result word is checked before the new request is predicted,
    // since a result seen at this edge always belongs to an earlier request.
    always @(posedge i_clk) begin
        t_res want;
        t_res got;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                got = o_res;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result word with nothing outstanding: %h", got));
                end else begin
                    want = expected_results.pop_front();
                    if (got.front_value !== want.front_value)
                        report_mismatch($sformatf("front_value %h, expected %h",
                                                  got.front_value, want.front_value));
                    if (got.count !== want.count)
                        report_mismatch($sformatf("count %0d, expected %0d",
                                                  got.count, want.count));
                    if (got.empty_res !== want.empty_res)
                        report_mismatch($sformatf("empty_res %b, expected %b",
                                                  got.empty_res, want.empty_res));
                    if (got.error !== want.error)
                        report_mismatch($sformatf("error %s, expected %s",
                                                  got.error.name(), want.error.name()));
                end
            end
            if (i_start && o_busy === 1'b0) begin
                // The deque is always updated; a typed row only replaces the prediction.
                want = deque_apply(i_req);
                expected_results.push_back(word_typed ? word_typed_res : want);
                words_taken++;
            end
        end
    end

    // Watchdog: a hung block or a lost handshake ends the run here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_res make_res(input logic signed [VALUE_W-1:0] front,
                                      input int count, input t_err err);
        t_res r;
        r.front_value = front;
        r.count       = CNT_W'(count);
        r.empty_res   = (count == 0);
        r.error       = err;
        return r;
    endfunction

    task automatic add_row(input t_func func, input logic [VALUE_W-1:0] value,
                           input int position, input bit use_last, input bit typed,
                           input t_res res);
        t_row row;
        row.req.func     = func;
        row.req.value    = value;
        row.req.position = POS_W'(position);
        row.req.use_last = use_last;
        row.typed        = typed;
        row.res          = res;
        directed_rows.push_back(row);
    endtask

    // Directed words: removals from an empty queue, the value extremes, range errors just past
    // the fill and at the top of the position field, a push into a full queue and erases at the
    // back, the middle and by the last-element flag. Pops carry junk values, which must be ignored.
    task automatic load_directed_rows();
        t_res none;
        none = make_res('0, 0, ERR_OK);
        add_row(FUNC_POP_FRONT, 64'hDEAD_BEEF_0BAD_F00D, 0, 1'b0, 1'b1,
                make_res('0, 0, ERR_EMPTY));
        add_row(FUNC_POP_BACK, 64'hFFFF_FFFF_FFFF_FFFF, 15, 1'b1, 1'b1,
                make_res('0, 0, ERR_EMPTY));
        add_row(FUNC_ERASE, '0, 0, 1'b0, 1'b1, make_res('0, 0, ERR_EMPTY));
        add_row(FUNC_ERASE, '0, 15, 1'b1, 1'b1, make_res('0, 0, ERR_EMPTY));
        add_row(FUNC_PUSH_BACK, VALUE_MAX, 0, 1'b0, 1'b1, make_res(VALUE_MAX, 1, ERR_OK));
        add_row(FUNC_PUSH_BACK, VALUE_MIN, 15, 1'b1, 1'b1, make_res(VALUE_MAX, 2, ERR_OK));
        add_row(FUNC_ERASE, '0, 2, 1'b0, 1'b1, make_res(VALUE_MAX, 2, ERR_RANGE));
        add_row(FUNC_ERASE, '0, 15, 1'b0, 1'b1, make_res(VALUE_MAX, 2, ERR_RANGE));
        for (int i = 2; i < DEPTH; i++) begin
            add_row(FUNC_PUSH_BACK, (i % 2) ? 64'hAAAA_AAAA_AAAA_AAAA + i
                                             : 64'h5555_5555_5555_5555 - i,
                    i, 1'(i % 2), 1'b0, none);
        end
        add_row(FUNC_PUSH_BACK, 64'h0123_4567_89AB_CDEF, 0, 1'b0, 1'b1,
                make_res(VALUE_MAX, DEPTH, ERR_FULL));
        add_row(FUNC_ERASE, '0, DEPTH - 1, 1'b0, 1'b1, make_res(VALUE_MAX, DEPTH - 1, ERR_OK));
        add_row(FUNC_ERASE, '0, 7, 1'b0, 1'b0, none);
        add_row(FUNC_ERASE, '0, 0, 1'b1, 1'b0, none);
        add_row(FUNC_POP_FRONT, 64'h1, 0, 1'b0, 1'b0, none);
        add_row(FUNC_POP_BACK, 64'h2, 0, 1'b0, 1'b0, none);
    endtask

    // Random request word. Most words follow a tide that fills the queue to the top and
    // drains it to empty, so every count and both boundary errors are reached; erase
    // positions are mostly in range. The rest is unshaped noise.
    function automatic t_req make_random_req();
        t_req r;
        int   pick;
        r.value = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0) r.value = $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
        r.position = POS_W'($urandom_range(0, 15));
        r.use_last = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 15) begin
            r.func = t_func'($urandom_range(0, 3));
            return r;
        end
        if (dq_fill >= DEPTH) filling = 1'b0;
        else if (dq_fill == 0) filling = 1'b1;
        else if ($urandom_range(0, 49) == 0) filling = !filling;
        if ($urandom_range(0, 99) < (filling ? 70 : 25)) begin
            r.func = FUNC_PUSH_BACK;
        end else begin
            pick = $urandom_range(0, 2);
            r.func = (pick == 0) ? FUNC_POP_FRONT : (pick == 1) ? FUNC_POP_BACK : FUNC_ERASE;
            r.use_last = ($urandom_range(0, 9) < 3);
            if (dq_fill > 0 && $urandom_range(0, 99) < 85)
                r.position = POS_W'($urandom_range(0, dq_fill - 1));
        end
        return r;
    endfunction

    // Offers one request word and returns at the falling edge after it has been taken.
    // With no gap, i_start simply stays high and only the request changes.
    task automatic send_word(input t_req r, input bit typed, input t_res typed_res);
        int gap;
        int seen;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req          <= r;
        i_start        <= 1'b1;
        word_typed     = typed;
        word_typed_res = typed_res;
        seen = words_taken;
        do @(negedge i_clk); while (words_taken == seen);
    endtask

    initial begin
        t_res none;
        none        = make_res('0, 0, ERR_OK);
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_req       = '0;
        dq_fill     = 0;
        words_taken = 0;
        mismatches  = 0;
        cycles      = 0;
        word_typed  = 1'b0;
        filling     = 1'b1;
        no_idle     = 1'b0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        load_directed_rows();
        foreach (directed_rows[k]) begin
            send_word(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].res);
        end

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // Alternate stretches of random gaps with stretches of back-to-back requests.
            if (n % 100 == 0) no_idle = ($urandom_range(0, 2) == 0);
            if (n == RANDOM_WORDS / 2) begin
                // Hold the next request back until the block has answered everything.
                i_start <= 1'b0;
                do @(negedge i_clk); while (expected_results.size() != 0);
            end
            send_word(make_random_req(), 1'b0, none);
        end
        i_start <= 1'b0;

        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived",
                                      expected_results.size()));

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
